// ===== rtl/dncal_pkg.sv =====
// ----------------------------------------------------------------------------
// Day number to calendar date: shared package
// Item types, cycle lengths, reciprocal constants and the month start table.
// ----------------------------------------------------------------------------
package dncal_pkg;

  // Register stages between the input and output transfer
  localparam int unsigned NumStages = 8;

  // Calendar cycle constants
  localparam int unsigned ShiftToCycleStart = 32044;
  localparam int unsigned DaysPer400y       = 146097;
  localparam int unsigned DaysPer100y       = 36524;
  localparam int unsigned DaysPer4y         = 1461;
  localparam int unsigned DaysPer1y         = 365;
  localparam int unsigned YearOffset        = 4800;
  localparam int unsigned MonthNumBias      = 308;

  // Reciprocals, floor(2^32/d) unless noted; the quotient may read one low
  localparam int unsigned Recip400y = 29398;     // 2^32 / 146097
  localparam int unsigned Recip4y   = 45933;     // 2^26 / 1461
  localparam int unsigned Recip100  = 42949672;  // 2^32 / 100
  localparam int unsigned Recip60   = 71582788;  // 2^32 / 60
  // ceil(2^20/153): exact for every numerator this block produces
  localparam int unsigned Recip153  = 6854;

  typedef struct packed {
    logic [23:0] day_count;
    logic [31:0] centiseconds;
  } in_item_t;

  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [7:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
  } res_item_t;

  // Day of a March-based year on which month mon starts, plus 122
  function automatic logic [8:0] month_start(input logic [3:0] mon);
    logic [8:0] val;
    case (mon)
      4'd0:    val = 9'd122;
      4'd1:    val = 9'd153;
      4'd2:    val = 9'd183;
      4'd3:    val = 9'd214;
      4'd4:    val = 9'd244;
      4'd5:    val = 9'd275;
      4'd6:    val = 9'd306;
      4'd7:    val = 9'd336;
      4'd8:    val = 9'd367;
      4'd9:    val = 9'd397;
      4'd10:   val = 9'd428;
      4'd11:   val = 9'd459;
      default: val = 9'd122;
    endcase
    return val;
  endfunction

endpackage

// ===== rtl/day_number_to_calendar_date_top.sv =====
// ----------------------------------------------------------------------------
// Day number to calendar date converter
// Turns a day count from the Julian epoch and a count of hundredths of a
// second into a proleptic Gregorian date and a time of day.
// ----------------------------------------------------------------------------
// The converter is an eight-stage pipeline: it takes one timestamp per clock
// unless the output side stalls a full pipe, and delivers each result when
// the output side is ready. Division by 146097, 1461, 100 or 60 is a
// reciprocal multiply in one stage and a one-step correction in the next,
// and those pairs set the depth; division by 153 needs no correction. Each
// stage holds its item when the stage after it is full and stalled, so
// bubbles close up and the input stays ready until all eight stages hold an
// item. The year wraps modulo 65536, and hours are the low 8 bits of the
// whole-hour count; a time of a day or more is not folded into the date.
module day_number_to_calendar_date_top
  import dncal_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output res_item_t out_data_o
);

  logic [NumStages-1:0] valid_q;
  logic [NumStages:0]   stage_rdy;

  // Stage 1: shift to cycle start, reciprocal multiplies
  logic [24:0] s1_d0_q, s1_d0_d;
  logic [39:0] s1_p400_q, s1_p400_d;
  logic [31:0] s1_cs_q;
  logic [57:0] s1_pc_q, s1_pc_d;
  // Stage 2: 400-year cycle, seconds count
  logic [6:0]  s2_q400_q, s2_q400_d;
  logic [17:0] s2_d1_q, s2_d1_d;
  logic [25:0] s2_t_q, s2_t_d;
  // Stage 3: 100-year cycle
  logic [15:0] s3_yhi_q, s3_yhi_d;
  logic [15:0] s3_d2_q, s3_d2_d;
  logic [25:0] s3_t_q;
  logic [52:0] s3_pt_q, s3_pt_d;
  // Stage 4
  logic [15:0] s4_yhi_q;
  logic [31:0] s4_p4_q, s4_p4_d;
  logic [15:0] s4_d2_q;
  logic [5:0]  s4_sec_q, s4_sec_d;
  logic [19:0] s4_m_q, s4_m_d;
  // Stage 5: 4-year cycle
  logic [15:0] s5_y_q, s5_y_d;
  logic [10:0] s5_d3_q, s5_d3_d;
  logic [5:0]  s5_sec_q;
  logic [19:0] s5_m_q;
  logic [46:0] s5_pm_q, s5_pm_d;
  // Stage 6: single years, hours and minutes
  logic [15:0] s6_y_q, s6_y_d;
  logic [8:0]  s6_d4_q, s6_d4_d;
  logic [5:0]  s6_sec_q, s6_min_q, s6_min_d;
  logic [7:0]  s6_hours_q, s6_hours_d;
  // Stage 7: month number
  logic [15:0] s7_y_q;
  logic [8:0]  s7_d4_q;
  logic [3:0]  s7_mon_q, s7_mon_d;
  logic [5:0]  s7_sec_q, s7_min_q;
  logic [7:0]  s7_hours_q;
  // Stage 8: result
  res_item_t   res_q, res_d;

  // A stage takes new data when it is empty or its contents move on
  always_comb begin
    stage_rdy[NumStages] = out_ready_i;
    for (int i = NumStages - 1; i >= 0; i--) begin
      stage_rdy[i] = !valid_q[i] || stage_rdy[i+1];
    end
  end

  assign in_ready_o  = stage_rdy[0];
  assign out_valid_o = valid_q[NumStages-1];
  assign out_data_o  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (stage_rdy[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int i = 1; i < NumStages; i++) begin
        if (stage_rdy[i]) begin
          valid_q[i] <= valid_q[i-1];
        end
      end
    end
  end

  // Stage 1
  always_comb begin
    s1_d0_d   = 25'(in_data_i.day_count) + 25'(ShiftToCycleStart);
    s1_p400_d = 40'(s1_d0_d) * 40'(Recip400y);
    s1_pc_d   = 58'(in_data_i.centiseconds) * 58'(Recip100);
  end

  // Stage 2: correct both quotients by at most one
  always_comb begin
    logic [6:0]  q400e;
    logic [24:0] rem400;
    logic [25:0] te;
    logic [31:0] rem100;
    q400e  = s1_p400_q[38:32];
    rem400 = s1_d0_q - 25'(q400e) * 25'(DaysPer400y);
    if (rem400 >= 25'(DaysPer400y)) begin
      s2_q400_d = q400e + 7'd1;
      s2_d1_d   = 18'(rem400 - 25'(DaysPer400y));
    end else begin
      s2_q400_d = q400e;
      s2_d1_d   = 18'(rem400);
    end
    te     = s1_pc_q[57:32];
    rem100 = s1_cs_q - 32'(te) * 32'd100;
    s2_t_d = (rem100 >= 32'd100) ? te + 26'd1 : te;
  end

  // Stage 3: the last century of a 400-year cycle absorbs the leap day
  always_comb begin
    logic [1:0] q100;
    if (s2_d1_q >= 18'(3 * DaysPer100y)) begin
      q100 = 2'd3;
    end else if (s2_d1_q >= 18'(2 * DaysPer100y)) begin
      q100 = 2'd2;
    end else if (s2_d1_q >= 18'(DaysPer100y)) begin
      q100 = 2'd1;
    end else begin
      q100 = 2'd0;
    end
    s3_d2_d  = 16'(s2_d1_q - 18'(q100) * 18'(DaysPer100y));
    s3_yhi_d = 16'(s2_q400_q) * 16'd400 + 16'(q100) * 16'd100;
    s3_pt_d  = 53'(s2_t_q) * 53'(Recip60);
  end

  // Stage 4
  always_comb begin
    logic [19:0] me;
    logic [25:0] rem;
    s4_p4_d = 32'(s3_d2_q) * 32'(Recip4y);
    me      = s3_pt_q[51:32];
    rem     = s3_t_q - 26'(me) * 26'd60;
    if (rem >= 26'd60) begin
      s4_sec_d = 6'(rem - 26'd60);
      s4_m_d   = me + 20'd1;
    end else begin
      s4_sec_d = 6'(rem);
      s4_m_d   = me;
    end
  end

  // Stage 5
  always_comb begin
    logic [4:0]  q4e, q4;
    logic [15:0] rem;
    q4e = s4_p4_q[30:26];
    rem = s4_d2_q - 16'(q4e) * 16'(DaysPer4y);
    if (rem >= 16'(DaysPer4y)) begin
      q4      = q4e + 5'd1;
      s5_d3_d = 11'(rem - 16'(DaysPer4y));
    end else begin
      q4      = q4e;
      s5_d3_d = 11'(rem);
    end
    s5_y_d  = s4_yhi_q + (16'(q4) << 2);
    s5_pm_d = 47'(s4_m_q) * 47'(Recip60);
  end

  // Stage 6: the last year of a 4-year cycle absorbs the leap day
  always_comb begin
    logic [1:0]  q1;
    logic [14:0] he;
    logic [19:0] rem;
    if (s5_d3_q >= 11'(3 * DaysPer1y)) begin
      q1 = 2'd3;
    end else if (s5_d3_q >= 11'(2 * DaysPer1y)) begin
      q1 = 2'd2;
    end else if (s5_d3_q >= 11'(DaysPer1y)) begin
      q1 = 2'd1;
    end else begin
      q1 = 2'd0;
    end
    s6_d4_d = 9'(s5_d3_q - 11'(q1) * 11'(DaysPer1y));
    s6_y_d  = s5_y_q + 16'(q1) - 16'(YearOffset);
    he      = s5_pm_q[46:32];
    rem     = s5_m_q - 20'(he) * 20'd60;
    if (rem >= 20'd60) begin
      s6_min_d   = 6'(rem - 20'd60);
      s6_hours_d = 8'(he + 15'd1);
    end else begin
      s6_min_d   = 6'(rem);
      s6_hours_d = 8'(he);
    end
  end

  // Stage 7: month counted from March
  always_comb begin
    logic [11:0] num;
    logic [24:0] prod;
    num      = 12'(s6_d4_q) * 12'd5 + 12'(MonthNumBias);
    prod     = 25'(num) * 25'(Recip153);
    s7_mon_d = prod[23:20] - 4'd2;
  end

  // Stage 8: back to a January-based year
  always_comb begin
    logic [9:0] day;
    logic       late;
    late = (s7_mon_q >= 4'd10);
    day  = 10'(s7_d4_q) + 10'd123 - 10'(month_start(s7_mon_q));
    res_d.year         = s7_y_q + 16'(late);
    res_d.month        = late ? s7_mon_q - 4'd9 : s7_mon_q + 4'd3;
    res_d.day_of_month = day[4:0];
    res_d.hours        = s7_hours_q;
    res_d.minutes      = s7_min_q;
    res_d.seconds      = s7_sec_q;
  end

  always_ff @(posedge clk_i) begin
    if (stage_rdy[0]) begin
      s1_d0_q   <= s1_d0_d;
      s1_p400_q <= s1_p400_d;
      s1_cs_q   <= in_data_i.centiseconds;
      s1_pc_q   <= s1_pc_d;
    end
    if (stage_rdy[1]) begin
      s2_q400_q <= s2_q400_d;
      s2_d1_q   <= s2_d1_d;
      s2_t_q    <= s2_t_d;
    end
    if (stage_rdy[2]) begin
      s3_yhi_q <= s3_yhi_d;
      s3_d2_q  <= s3_d2_d;
      s3_t_q   <= s2_t_q;
      s3_pt_q  <= s3_pt_d;
    end
    if (stage_rdy[3]) begin
      s4_yhi_q <= s3_yhi_q;
      s4_p4_q  <= s4_p4_d;
      s4_d2_q  <= s3_d2_q;
      s4_sec_q <= s4_sec_d;
      s4_m_q   <= s4_m_d;
    end
    if (stage_rdy[4]) begin
      s5_y_q   <= s5_y_d;
      s5_d3_q  <= s5_d3_d;
      s5_sec_q <= s4_sec_q;
      s5_m_q   <= s4_m_q;
      s5_pm_q  <= s5_pm_d;
    end
    if (stage_rdy[5]) begin
      s6_y_q     <= s6_y_d;
      s6_d4_q    <= s6_d4_d;
      s6_sec_q   <= s5_sec_q;
      s6_min_q   <= s6_min_d;
      s6_hours_q <= s6_hours_d;
    end
    if (stage_rdy[6]) begin
      s7_y_q     <= s6_y_q;
      s7_d4_q    <= s6_d4_q;
      s7_mon_q   <= s7_mon_d;
      s7_sec_q   <= s6_sec_q;
      s7_min_q   <= s6_min_q;
      s7_hours_q <= s6_hours_q;
    end
    if (stage_rdy[7]) begin
      res_q <= res_d;
    end
  end

  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.month >= 4'd1 && out_data_o.month <= 4'd12))
    else $error("month out of range");

  a_day_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.day_of_month != 5'd0))
    else $error("day of month is zero");

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.minutes < 6'd60 && out_data_o.seconds < 6'd60))
    else $error("minutes or seconds out of range");

  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&valid_q))
    else $error("input blocked while a stage is empty");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[NumStages-2] && !stage_rdy[NumStages-1]) |=> valid_q[NumStages-2])
    else $error("stalled item dropped");

endmodule

// ===== test/day_number_to_calendar_date_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Day number to calendar date converter: testbench
// Drives timestamps through the valid/ready input and predicts each
// Gregorian date and time of day. Every result transfer is compared field by
// field against the oldest prediction. Idling, stalls and hold-off vary by phase.
// ----------------------------------------------------------------------------
module day_number_to_calendar_date_top_tb;
  import dncal_pkg::*;

  localparam int unsigned HalfPeriod    = 5;
  localparam int unsigned ResetCycles   = 5;
  localparam int unsigned PipeDepth     = 8;
  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned MaxReports    = 10;
  localparam int unsigned RandPerPhase  = 250;
  localparam int unsigned HoldOffCycles = 60;
  localparam int unsigned BurstItems    = 30;

  // Calendar arithmetic
  localparam int unsigned EpochShift    = 32044;
  localparam int unsigned Days400       = 146097;
  localparam int unsigned Days100       = 36524;
  localparam int unsigned Days4         = 1461;
  localparam int unsigned Days1         = 365;
  localparam int unsigned MarchYearBias = 4800;
  localparam int unsigned CsPerDay      = 8640000;
  localparam int unsigned FirstAdDay    = 1721425;

  class cal_scoreboard;
    res_item_t   dates_due_q[$];
    int unsigned n_noted;
    int unsigned n_checked;
    int unsigned n_bad;

    function new();
      n_noted   = 0;
      n_checked = 0;
      n_bad     = 0;
    endfunction

    function res_item_t to_calendar(in_item_t ts);
      int unsigned d, q400, q100, q4, q1, yrs, mon, t;
      res_item_t   r;
      // move to the start of a 400-year cycle, then peel off the cycles
      d    = ts.day_count + EpochShift;
      q400 = d / Days400;
      d    = d % Days400;
      q100 = ((d / Days100 + 1) * 3) / 4;
      d    = d - q100 * Days100;
      q4   = d / Days4;
      d    = d % Days4;
      q1   = ((d / Days1 + 1) * 3) / 4;
      d    = d - q1 * Days1;
      yrs  = q400 * 400 + q100 * 100 + q4 * 4 + q1;
      // months counted from March
      mon  = (d * 5 + 308) / 153 - 2;
      d    = d + 122 - ((mon + 4) * 153) / 5;
      r.year         = 16'(yrs - MarchYearBias + (mon + 2) / 12);
      r.month        = 4'((mon + 2) % 12 + 1);
      r.day_of_month = 5'(d + 1);
      t              = ts.centiseconds / 100;
      r.seconds      = 6'(t % 60);
      t              = t / 60;
      r.minutes      = 6'(t % 60);
      t              = t / 60;
      r.hours        = 8'(t);
      return r;
    endfunction

    function void note_input(in_item_t ts);
      dates_due_q.push_back(to_calendar(ts));
      n_noted++;
    endfunction

    function void check_result(res_item_t got);
      res_item_t want;
      bit        ok;
      if (dates_due_q.size() == 0) begin
        n_bad++;
        if (n_bad <= MaxReports) begin
          $display("ERROR: result with nothing outstanding: %0d-%0d-%0d %0d:%0d:%0d",
                   got.year, got.month, got.day_of_month, got.hours, got.minutes,
                   got.seconds);
        end
        return;
      end
      want = dates_due_q.pop_front();
      n_checked++;
      ok = (got.year == want.year) && (got.month == want.month) &&
           (got.day_of_month == want.day_of_month) && (got.hours == want.hours) &&
           (got.minutes == want.minutes) && (got.seconds == want.seconds);
      if (!ok) begin
        n_bad++;
        if (n_bad <= MaxReports) begin
          $display({"ERROR: result %0d: expected %0d-%0d-%0d %0d:%0d:%0d, ",
                    "got %0d-%0d-%0d %0d:%0d:%0d"},
                   n_checked, want.year, want.month, want.day_of_month, want.hours,
                   want.minutes, want.seconds, got.year, got.month, got.day_of_month,
                   got.hours, got.minutes, got.seconds);
        end
      end
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  res_item_t out_data;

  cal_scoreboard sb = new();

  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_req  = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned cycles    = 0;
  int unsigned n_directed = 0;

  day_number_to_calendar_date_top u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always #(HalfPeriod) clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles,
               sb.dates_due_q.size());
      $display("** day_number_to_calendar_date_top: FAILED **");
      $finish;
    end
  end

  // Receiver: a new hold-off request starts the count, a pending hold-off
  // wins over the random stall
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      out_ready <= 1'b0;
      hold_seen <= hold_req;
      hold_left <= HoldOffCycles - 1;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sb.note_input(in_data);
      end
      if (out_valid && out_ready) begin
        sb.check_result(out_data);
      end
    end
  end

  // Offer one timestamp, after a random gap, and hold it until the transfer
  task automatic send_ts(input in_item_t ts);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= ts;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_pair(input logic [23:0] days, input logic [31:0] cs);
    in_item_t ts;
    ts.day_count    = days;
    ts.centiseconds = cs;
    send_ts(ts);
    n_directed++;
  endtask

  // Drop valid and wait for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.dates_due_q.size() != 0) @(posedge clk);
  endtask

  function automatic in_item_t rand_ts();
    in_item_t    ts;
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 4) begin
      // dates from AD 763 to AD 2406, time within one day
      ts.day_count    = 24'($urandom_range(2600000, 2000000));
      ts.centiseconds = $urandom_range(CsPerDay - 1);
    end else if (pick < 6) begin
      // years BC, wrapping the year field
      ts.day_count    = 24'($urandom_range(FirstAdDay));
      ts.centiseconds = $urandom_range(CsPerDay - 1);
    end else if (pick < 8) begin
      ts.day_count    = 24'($urandom);
      ts.centiseconds = $urandom_range(CsPerDay - 1);
    end else begin
      ts.day_count    = 24'($urandom);
      ts.centiseconds = $urandom;
    end
    return ts;
  endfunction

  task automatic run_random(input int unsigned n, input int unsigned idle,
                            input int unsigned stall);
    idle_pct  = idle;
    stall_pct = stall;
    repeat (n) send_ts(rand_ts());
    drain();
  endtask

  initial begin
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // field extremes
    send_pair(24'd0, 32'd0);
    send_pair(24'hFFFFFF, 32'hFFFFFFFF);
    send_pair(24'h800000, 32'hAAAAAAAA);
    send_pair(24'h7FFFFF, 32'h55555555);
    send_pair(24'd1, 32'd1);
    // year end and day rollover in the time of day
    send_pair(24'd2451544, CsPerDay - 1);
    send_pair(24'd2451545, CsPerDay);
    // leap day in a 400-year leap century
    send_pair(24'd2451603, 32'd99);
    send_pair(24'd2451604, 32'd100);
    send_pair(24'd2451605, 32'd5999);
    // century that is not a leap year
    send_pair(24'd2415078, 32'd6000);
    send_pair(24'd2415079, 32'd359999);
    send_pair(24'd2415080, 32'd360000);
    // around year 1 and year 0 (1 BC); hours field wrap at 256
    send_pair(24'd1721423, 32'd92159999);
    send_pair(24'd1721424, 32'd92160000);
    send_pair(24'd1721425, 32'h80000000);
    send_pair(24'd1721426, 32'h7FFFFFFF);
    send_pair(24'd2299160, 32'd0);
    send_pair(24'd2299161, 32'd12345678);
    send_pair(24'd2440587, 32'd8639900);
    send_pair(24'd2440588, 32'd0);
    send_pair(24'd2460000, 32'd4320000);
    drain();

    run_random(RandPerPhase, 0, 0);
    run_random(RandPerPhase, 68, 0);

    // hold off the receiver while a burst keeps coming, so the pipe fills
    idle_pct  = 0;
    stall_pct = 0;
    hold_req  = hold_req + 1;
    repeat (BurstItems) send_ts(rand_ts());
    drain();

    run_random(RandPerPhase, 0, 68);
    run_random(RandPerPhase, 22, 22);

    repeat (3 * PipeDepth) @(posedge clk);

    $display("Ran %0d timestamps (%0d directed) through free-running, sender-gap,",
             sb.n_noted, n_directed);
    $display("receiver-stall, mixed and %0d-cycle hold-off phases; %0d results compared",
             HoldOffCycles, sb.n_checked);
    if (sb.dates_due_q.size() != 0) begin
      $display("ERROR: %0d results never arrived", sb.dates_due_q.size());
    end
    if (sb.n_bad == 0 && sb.dates_due_q.size() == 0) begin
      $display("** day_number_to_calendar_date_top: PASSED **");
    end else begin
      $display("%0d mismatches", sb.n_bad);
      $display("** day_number_to_calendar_date_top: FAILED **");
    end
    $finish;
  end

endmodule
